// File: sv/lsl_pkg.sv
// ----------------------------------------------------------------------------
// lsl_pkg: shared types and constants
// Result item layout, status codes and line limits of the S-record loader.
// ----------------------------------------------------------------------------
package lsl_pkg;

  localparam int unsigned MaxLine = 530;
  localparam int unsigned PosW    = 10;
  localparam logic [PosW-1:0] PosLimit = PosW'(MaxLine - 2);
  localparam logic [PosW-1:0] PosSat   = PosW'(1023);

  localparam logic [1:0] StOk   = 2'd0;
  localparam logic [1:0] StSum  = 2'd1;
  localparam logic [1:0] StAddr = 2'd2;
  localparam logic [1:0] StLine = 2'd3;

  localparam logic [1:0] CfgOffset = 2'd0;
  localparam logic [1:0] CfgRom    = 2'd1;
  localparam logic [1:0] CfgSwap   = 2'd2;

  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChS       = 8'h53;
  localparam logic [7:0] SumGood   = 8'hFF;

  typedef struct packed {
    logic        write_valid;
    logic [31:0] write_addr;
    logic [7:0]  write_data;
    logic        line_done;
    logic [1:0]  status;
  } res_t;

  typedef struct packed {
    logic [31:0] address_offset;
    logic [31:0] rom_bytes;
    logic        swap_halves;
  } cfg_t;

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) v = 4'(c - 8'h30);
    else if (c >= 8'h41 && c <= 8'h46) v = 4'(c - 8'h37);
    else if (c >= 8'h61 && c <= 8'h66) v = 4'(c - 8'h57);
    return v;
  endfunction

endpackage

// File: sv/lsl_front.sv
// ----------------------------------------------------------------------------
// lsl_front: character decoder
// Takes one character per cycle while take_i is high, tracks the line state and forms result items.
// ----------------------------------------------------------------------------
module lsl_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  lsl_pkg::cfg_t cfg_i,
  input  logic          take_i,
  input  logic [7:0]    char_i,
  output logic          push_o,
  output lsl_pkg::res_t res_o
);
  import lsl_pkg::*;

  logic [PosW-1:0] pos_q, pos_d;
  logic [1:0]  kind_q, kind_d;
  logic [7:0]  count_q, count_d;
  logic [7:0]  hi_q, hi_d;
  logic [31:0] acc_q, acc_d;
  logic [7:0]  sum_q, sum_d;
  logic [31:0] nwa_q, nwa_d;
  logic [1:0]  err_q, err_d;

  logic [PosW-1:0] k;
  logic [8:0]  idx;
  logic [7:0]  b;
  logic [8:0]  alen;
  logic [31:0] acc_new;
  logic [31:0] phys;
  logic [PosW-2:0] got;

  always_comb begin
    pos_d   = pos_q;
    kind_d  = kind_q;
    count_d = count_q;
    hi_d    = hi_q;
    acc_d   = acc_q;
    sum_d   = sum_q;
    nwa_d   = nwa_q;
    err_d   = err_q;
    push_o  = 1'b0;
    res_o   = '0;
    k       = pos_q - PosW'(2);
    idx     = 9'(k >> 1);
    b       = hi_q | {4'd0, hex_value(char_i)};
    alen    = {7'd0, kind_q} + 9'd1;
    acc_new = {acc_q[23:0], b};
    phys    = nwa_q ^ {31'd0, cfg_i.swap_halves};
    got     = (pos_q >= PosW'(2)) ? k[PosW-1:1] : '0;
    if (char_i == ChNewline) begin
      if (pos_q == '0) begin
        if (err_q == StOk) err_d = StLine;
      end else if (kind_q != 2'd0 && err_q == StOk) begin
        if ({1'b0, got} < {2'b0, count_q} + 10'd1 || sum_q != SumGood) err_d = StSum;
      end
      push_o          = 1'b1;
      res_o.line_done = 1'b1;
      res_o.status    = err_d;
      pos_d = '0; kind_d = '0; count_d = '0; hi_d = '0;
      acc_d = '0; sum_d = '0; nwa_d = '0;
    end else if (pos_q >= PosLimit) begin
      if (err_q == StOk) err_d = StLine;
      kind_d = 2'd0;
    end else begin
      if (pos_q == '0) begin
        if (char_i != ChS) begin
          if (err_q == StOk) err_d = StLine;
          kind_d = 2'd0;
        end
      end else if (pos_q == PosW'(1)) begin
        if (err_q == StOk) begin
          case (char_i)
            8'h31:   kind_d = 2'd1;
            8'h32:   kind_d = 2'd2;
            8'h33:   kind_d = 2'd3;
            default: kind_d = 2'd0;
          endcase
        end
      end else if (kind_q != 2'd0) begin
        if (!k[0]) begin
          hi_d = {hex_value(char_i), 4'd0};
        end else if (idx <= 9'd255) begin
          if (idx == 9'd0) count_d = b;
          if (idx <= {1'b0, count_d}) sum_d = sum_q + b;
          if (idx >= 9'd1 && idx <= alen) begin
            acc_d = acc_new;
            if (idx == alen) begin
              if (acc_new < cfg_i.address_offset) begin
                if (err_q == StOk) err_d = StAddr;
              end else begin
                nwa_d = acc_new - cfg_i.address_offset;
              end
            end
          end else if (idx > alen && idx < {1'b0, count_q}) begin
            if (err_q == StOk && nwa_q < cfg_i.rom_bytes && phys < cfg_i.rom_bytes) begin
              push_o            = 1'b1;
              res_o.write_valid = 1'b1;
              res_o.write_addr  = phys;
              res_o.write_data  = b;
            end
            if (nwa_q != 32'hFFFF_FFFF) nwa_d = nwa_q + 32'd1;
          end
        end
      end
      if (pos_q < PosSat) pos_d = pos_q + PosW'(1);
    end
    if (!take_i) push_o = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0; kind_q <= '0; count_q <= '0; hi_q <= '0;
      acc_q <= '0; sum_q <= '0; nwa_q <= '0; err_q <= '0;
    end else if (take_i) begin
      pos_q <= pos_d; kind_q <= kind_d; count_q <= count_d; hi_q <= hi_d;
      acc_q <= acc_d; sum_q <= sum_d; nwa_q <= nwa_d; err_q <= err_d;
    end
  end

endmodule

// File: sv/lsl_queue.sv
// ----------------------------------------------------------------------------
// lsl_queue: two-entry result queue
// Decouples the decoder from the output stage.
// ----------------------------------------------------------------------------
module lsl_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  lsl_pkg::res_t data_i,
  output logic          full_o,
  output logic          avail_o,
  input  logic          pop_i,
  output lsl_pkg::res_t data_o
);
  import lsl_pkg::*;

  res_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign avail_o = cnt_q != 2'd0;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

// File: sv/lsl_back.sv
// ----------------------------------------------------------------------------
// lsl_back: output stage
// Holds one result item toward the receiver, refilled from the queue.
// ----------------------------------------------------------------------------
module lsl_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          avail_i,
  input  lsl_pkg::res_t data_i,
  output logic          pop_o,
  output logic          valid_o,
  input  logic          ready_i,
  output lsl_pkg::res_t res_o
);
  import lsl_pkg::*;

  logic valid_q;
  res_t res_q;

  assign pop_o   = avail_i && (!valid_q || ready_i);
  assign valid_o = valid_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else if (pop_o) valid_q <= 1'b1;
    else if (ready_i) valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) res_q <= data_i;
  end

endmodule

// File: sv/srecord_line_loader.sv
// ----------------------------------------------------------------------------
// srecord_line_loader: S-record text to byte-write stream
// Decodes Motorola S-record lines one character per item.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : one character per item (line_char_i), newline ends a line.
//   out channel : zero or one result per character: a data byte write, or a
//                 line_done item with the sticky status on each newline.
//   cfg channel : index 0 offset, 1 image size, 2 swap; always ready. Write
//                 only while idle.
// Throughput: one character per cycle while the queue is not full; the decoder
//   updates its line state as it takes each character.
// Path: a result enters the queue at the edge that accepts its character and
//   moves on into the output register once that register is free or being read.
// Stall: a two-entry queue and the output register absorb results; in_ready
//   drops only when the queue is full.
// Reset: clears line state, the sticky error and the queues; config returns
//   to offset 0, size 65536, swap on.
// ----------------------------------------------------------------------------
module srecord_line_loader (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  line_char_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        write_valid_o,
  output logic [31:0] write_addr_o,
  output logic [7:0]  write_data_o,
  output logic        line_done_o,
  output logic [1:0]  status_o
);
  import lsl_pkg::*;

  cfg_t cfg_q;
  logic take, push, full, avail, pop;
  res_t f_res, q_res, o_res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.address_offset <= 32'd0;
      cfg_q.rom_bytes      <= 32'd65536;
      cfg_q.swap_halves    <= 1'b1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgOffset: cfg_q.address_offset <= cfg_data_i;
        CfgRom:    cfg_q.rom_bytes      <= cfg_data_i;
        CfgSwap:   cfg_q.swap_halves    <= cfg_data_i[0];
        default:   ;
      endcase
    end
  end

  assign in_ready_o = !full;
  assign take       = in_valid_i && !full;

  lsl_front u_front (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .take_i(take), .char_i(line_char_i),
    .push_o(push), .res_o(f_res)
  );

  lsl_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .data_i(f_res), .full_o(full),
    .avail_o(avail), .pop_i(pop), .data_o(q_res)
  );

  lsl_back u_back (
    .clk_i, .rst_ni, .avail_i(avail), .data_i(q_res), .pop_o(pop),
    .valid_o(out_valid_o), .ready_i(out_ready_i), .res_o(o_res)
  );

  assign write_valid_o = o_res.write_valid;
  assign write_addr_o  = o_res.write_addr;
  assign write_data_o  = o_res.write_data;
  assign line_done_o   = o_res.line_done;
  assign status_o      = o_res.status;

  a_kind_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (write_valid_o ^ line_done_o))
    else $error("result is neither write nor line_done");

  a_write_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && write_valid_o |-> status_o == StOk)
    else $error("write carries nonzero status");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !push)
    else $error("push into full queue");

  a_pop_avail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> avail)
    else $error("pop from empty queue");

endmodule

// File: dv/srecord_line_loader_tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking testbench for srecord_line_loader
// Feeds S-record text one character per item. A local line decoder predicts
// every write and line status. Results are checked in order while both sides
// stall at random, across several settings of offset, image size and swap.
// ----------------------------------------------------------------------------
module tb;
  import lsl_pkg::*;

  localparam int unsigned CycleLimit = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = CfgOffset;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  line_char_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        write_valid_o;
  logic [31:0] write_addr_o;
  logic [7:0]  write_data_o;
  logic        line_done_o;
  logic [1:0]  status_o;

  srecord_line_loader dut (.*);

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // decoder mirror
  logic [31:0] m_offset = 32'd0;
  logic [31:0] m_rom = 32'd65536;
  logic        m_swap = 1'b1;
  int unsigned m_pos = 0;
  int unsigned m_kind = 0;
  logic [7:0]  m_count = '0;
  logic [7:0]  m_hi = '0;
  logic [31:0] m_addr = '0;
  logic [7:0]  m_sum = '0;
  logic [31:0] m_next = '0;
  logic [1:0]  m_err = StOk;

  res_t        expected_results[$];
  logic [7:0]  pending_chars[$];

  int          send_idle = 0;
  int          recv_idle = 0;
  int          hold_reqs = 0;
  int          holds_seen = 0;
  int          hold_left = 0;
  int          mismatches = 0;
  int          cycles = 0;
  int          chars_sent = 0;
  int          writes_seen = 0;
  int          lines_seen = 0;

  function automatic logic [3:0] nibble_of(logic [7:0] c);
    case (c) inside
      ["0":"9"]: return 4'(c - "0");
      ["A":"F"]: return 4'(c - "A" + 10);
      ["a":"f"]: return 4'(c - "a" + 10);
      default:   return 4'd0;
    endcase
  endfunction

  task automatic raise(logic [1:0] code);
    if (m_err == StOk) m_err = code;
  endtask

  task automatic clear_line_state();
    m_pos = 0; m_kind = 0; m_count = '0; m_hi = '0;
    m_addr = '0; m_sum = '0; m_next = '0;
  endtask

  task automatic decode_byte(int unsigned idx, logic [7:0] b);
    int unsigned alen;
    logic [31:0] phys;
    res_t r;
    alen = m_kind + 1;
    if (idx > 255) return;
    if (idx == 0) m_count = b;
    if (idx <= m_count) m_sum = m_sum + b;
    if (idx >= 1 && idx <= alen) begin
      m_addr = {m_addr[23:0], b};
      if (idx == alen) begin
        if (m_addr < m_offset) raise(StAddr);
        else m_next = m_addr - m_offset;
      end
    end else if (idx > alen && idx < m_count) begin
      phys = m_next ^ {31'd0, m_swap};
      if (m_err == StOk && m_next < m_rom && phys < m_rom) begin
        r = '{write_valid: 1'b1, write_addr: phys, write_data: b,
              line_done: 1'b0, status: StOk};
        expected_results.push_back(r);
      end
      if (m_next != 32'hFFFF_FFFF) m_next++;
    end
  endtask

  task automatic decode_char(logic [7:0] c);
    int unsigned got;
    int unsigned k;
    res_t r;
    if (c == ChNewline) begin
      if (m_pos == 0) raise(StLine);
      else if (m_kind != 0 && m_err == StOk) begin
        got = (m_pos >= 2) ? (m_pos - 2) >> 1 : 0;
        if (got < m_count + 1 || m_sum != SumGood) raise(StSum);
      end
      r = '{write_valid: 1'b0, write_addr: '0, write_data: '0,
            line_done: 1'b1, status: m_err};
      expected_results.push_back(r);
      clear_line_state();
      return;
    end
    if (m_pos >= MaxLine - 2) begin
      raise(StLine);
      m_kind = 0;
      return;
    end
    if (m_pos == 0) begin
      if (c != ChS) begin
        raise(StLine);
        m_kind = 0;
      end
    end else if (m_pos == 1) begin
      if (m_err == StOk) begin
        if (c == "1") m_kind = 1;
        else if (c == "2") m_kind = 2;
        else if (c == "3") m_kind = 3;
        else m_kind = 0;
      end
    end else if (m_kind != 0) begin
      k = m_pos - 2;
      if (k[0] == 1'b0) m_hi = {nibble_of(c), 4'd0};
      else decode_byte(k >> 1, m_hi | {4'd0, nibble_of(c)});
    end
    if (m_pos < 1023) m_pos++;
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        decode_char(line_char_i);
        chars_sent++;
      end
      if (in_valid_i && !in_ready_o) begin
        in_valid_i <= 1'b1;
      end else if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle) begin
        in_valid_i  <= 1'b1;
        line_char_i <= pending_chars.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver stall, with long hold-offs on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (holds_seen != hold_reqs) begin
      holds_seen <= hold_reqs;
      hold_left  <= 400;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: wv=%0b addr=%h data=%h done=%0b st=%0d",
                   write_valid_o, write_addr_o, write_data_o, line_done_o, status_o);
      end else begin
        want = expected_results.pop_front();
        if (write_valid_o) writes_seen++;
        if (line_done_o) lines_seen++;
        if (want.write_valid !== write_valid_o || want.write_addr !== write_addr_o ||
            want.write_data !== write_data_o || want.line_done !== line_done_o ||
            want.status !== status_o) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: exp wv=%0b addr=%h data=%h done=%0b st=%0d",
                     want.write_valid, want.write_addr, want.write_data,
                     want.line_done, want.status);
            $display("          got wv=%0b addr=%h data=%h done=%0b st=%0d",
                     write_valid_o, write_addr_o, write_data_o,
                     line_done_o, status_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---- stimulus helpers ----
  function automatic logic [7:0] junk_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255));
    while (c == ChNewline || (c >= "0" && c <= "9") || (c >= "A" && c <= "F") ||
           (c >= "a" && c <= "f"));
    return c;
  endfunction

  // a zero nibble sometimes goes out as a non-hex character
  function automatic logic [7:0] digit_char(logic [3:0] n);
    if (n == 0 && $urandom_range(19) == 0) return junk_char();
    if (n < 10) return 8'("0" + n);
    return ($urandom_range(1) ? 8'("A" + n - 10) : 8'("a" + n - 10));
  endfunction

  task automatic queue_byte(logic [7:0] b);
    pending_chars.push_back(digit_char(b[7:4]));
    pending_chars.push_back(digit_char(b[3:0]));
  endtask

  task automatic queue_data_line(int k, logic [31:0] addr, int ndata,
                                 bit bad_sum = 0, bit cut = 0, bit tail = 0);
    logic [7:0] bytes[$];
    logic [7:0] sum;
    bytes.push_back(8'(k + 1 + ndata + 1));
    for (int i = k; i >= 0; i--) bytes.push_back(addr[8*i +: 8]);
    repeat (ndata) bytes.push_back(8'($urandom_range(255)));
    sum = '0;
    foreach (bytes[i]) sum += bytes[i];
    bytes.push_back(~sum ^ {7'd0, bad_sum});
    if (cut) void'(bytes.pop_back());
    pending_chars.push_back(ChS);
    pending_chars.push_back(8'("0" + k));
    foreach (bytes[i]) queue_byte(bytes[i]);
    if (tail) begin
      repeat ($urandom_range(1, 3)) queue_byte(8'($urandom_range(255)));
      if ($urandom_range(1)) pending_chars.push_back(digit_char(4'($urandom_range(15))));
    end
    pending_chars.push_back(ChNewline);
  endtask

  // record type is a non-data one: junk, S5 or S9
  task automatic queue_ignored_line(int len);
    logic [7:0] c;
    pending_chars.push_back(ChS);
    do c = junk_char(); while (c == "1" || c == "2" || c == "3");
    pending_chars.push_back($urandom_range(1) ? c : 8'("5" + 4 * $urandom_range(1)));
    repeat (len) pending_chars.push_back(junk_char());
    pending_chars.push_back(ChNewline);
  endtask

  task automatic queue_random_line();
    logic [31:0] addr;
    int k;
    int nd;
    if ($urandom_range(9) == 0) begin
      queue_ignored_line($urandom_range(0, 20));
      return;
    end
    addr = ($urandom_range(1)) ? m_offset + $urandom_range(0, 64)
                               : m_offset + m_rom - $urandom_range(0, 8);
    if (addr < m_offset) addr = m_offset;
    if (addr <= 32'hFFFF) k = $urandom_range(1, 3);
    else if (addr <= 32'hFF_FFFF) k = $urandom_range(2, 3);
    else k = 3;
    nd = $urandom_range(0, 16);
    queue_data_line(k, addr, nd, 0, 0, $urandom_range(7) == 0);
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_chars.size() != 0 || in_valid_i || expected_results.size() != 0);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CfgOffset: m_offset = val;
      CfgRom:    m_rom = val;
      CfgSwap:   m_swap = val[0];
      default: ;
    endcase
  endtask

  task automatic random_lines(int chars);
    int goal;
    goal = pending_chars.size() + chars;
    while (pending_chars.size() < goal) queue_random_line();
  endtask

  initial begin
    send_idle = 26;
    recv_idle = 69;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: default settings
    queue_data_line(1, 32'h0000, 2);
    queue_data_line(2, 32'h00_FFFE, 3);             // crosses image end
    queue_data_line(3, 32'h0000_0010, 1, 0, 0, 1);  // trailing bytes, odd digit
    queue_data_line(1, 32'hFFFF, 0);
    queue_ignored_line(6);
    pending_chars.push_back(ChS);                    // S with newline right after
    pending_chars.push_back(ChNewline);
    wait_idle();

    write_reg(CfgOffset, 32'd0);
    write_reg(CfgRom, 32'hFFFF_FFFF);
    write_reg(CfgSwap, 32'd0);
    queue_data_line(3, 32'hFFFF_FFFE, 3);            // address saturates
    queue_data_line(3, 32'h8000_0000, 250);          // longest count
    random_lines(60);
    hold_reqs++;                                     // long receiver hold-off
    random_lines(40);
    wait_idle();

    send_idle = 69;
    recv_idle = 26;
    write_reg(CfgOffset, 32'h0000_1000);
    write_reg(CfgRom, 32'h0000_0200);
    write_reg(CfgSwap, 32'd1);
    random_lines(60);
    wait_idle();

    send_idle = 0;
    recv_idle = 0;
    write_reg(CfgOffset, 32'hFFFF_FF00);
    write_reg(CfgRom, 32'h0000_0000);
    random_lines(30);
    wait_idle();
    write_reg(CfgOffset, 32'h0000_0100);
    write_reg(CfgRom, 32'h0000_0101);
    random_lines(40);
    wait_idle();

    // error cases last: the first one sticks until reset
    queue_data_line(1, 32'h0010, 2);                 // address below offset
    queue_data_line(1, 32'h0100, 2, 0, 1);           // short line
    queue_data_line(1, 32'h0100, 2, 1);              // bad checksum
    pending_chars.push_back(ChNewline);              // empty line
    pending_chars.push_back("X");
    pending_chars.push_back(ChNewline);
    pending_chars.push_back(ChS);
    pending_chars.push_back("9");
    repeat (530) pending_chars.push_back(junk_char());  // overlong line
    pending_chars.push_back(ChNewline);
    queue_data_line(1, 32'h0100, 3);
    wait_idle();

    $display("covered %0d characters, %0d writes and %0d line ends checked",
             chars_sent, writes_seen, lines_seen);
    $display("four register settings incl. extremes, swap on/off, sticky errors at end");
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
